[rtl/edt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// edt_pkg
// Shared widths, constants and types of the edge centroid tracker.
// ----------------------------------------------------------------------------
package edt_pkg;

   localparam int COL_W   = 7;
   localparam int ROW_W   = 6;
   localparam int CNT_W   = 13;
   localparam int SUM_W   = 19;
   localparam int RANGE_W = 16;
   localparam int DATA_W  = 32;
   localparam int ADDR_W  = 5;

   localparam int IMAGE_WIDTH_DEF  = 80;
   localparam int IMAGE_HEIGHT_DEF = 60;

   localparam logic [ROW_W-1:0]   ROW_START_RST  = 6'd4;
   localparam logic [ROW_W-1:0]   ROW_END_RST    = 6'd49;
   localparam logic [COL_W-1:0]   COL_START_RST  = 7'd5;
   localparam logic [COL_W-1:0]   COL_END_RST    = 7'd74;
   localparam logic [COL_W-1:0]   LOST_LIMIT_RST = 7'd21;
   localparam logic [RANGE_W-1:0] NEAR_LIMIT_RST = 16'd405;

   localparam logic [COL_W-1:0] LOST_WRAP_ABOVE = 7'd100;
   localparam logic [COL_W-1:0] LOST_WRAP_TO    = 7'd22;

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

   // register index, taken from paddr word offset
   typedef enum logic [2:0] {
      REG_ROW_START  = 3'd0,
      REG_ROW_END    = 3'd1,
      REG_COL_START  = 3'd2,
      REG_COL_END    = 3'd3,
      REG_LOST_LIMIT = 3'd4,
      REG_NEAR_LIMIT = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL_START,
      ST_COL_WAIT,
      ST_ROW_START,
      ST_ROW_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage
`default_nettype wire

[rtl/edt_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// edt_divider
// Restoring divider, one quotient bit per cycle through one shared subtractor.
// ----------------------------------------------------------------------------
module edt_divider (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [edt_pkg::SUM_W-1:0]   dividend,
   input  wire logic [edt_pkg::CNT_W-1:0]   divisor,
   output edt_pkg::div_status_type          status,
   output logic      [edt_pkg::SUM_W-1:0]   quotient
);
   import edt_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);

   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  div_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W+1:0]  diff;

   // shift in the next dividend bit and try one subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      diff    = {1'b0, trial} - {2'b00, div_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[CNT_W+1]) begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end else begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         if (start) begin
            step_ff <= STEP_W'(SUM_W - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule
`default_nettype wire

[rtl/edge_centroid_tracker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// edge_centroid_tracker
// Counts horizontal pixel transitions in a window and divides the column and
// row sums by the count at frame end to track a target centre.
// ----------------------------------------------------------------------------
// Throughput: one pixel word per cycle for all pixels but the last of a frame.
// Frame end: input stalls while the sequencer runs; with no transition in the frame
//   only the finish state runs, else two divider passes (start, 19 steps, done;
//   column then row) and the finish state, which stretches while the previous
//   result word is still waiting.
// Reset: synchronous, active high; sets register defaults, clears control state.
// ----------------------------------------------------------------------------
module edge_centroid_tracker #(
   parameter int IMAGE_WIDTH  = edt_pkg::IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT = edt_pkg::IMAGE_HEIGHT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // pixel channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_pixel,
   input  wire logic [edt_pkg::RANGE_W-1:0]   req_range_sample,
   input  wire logic                          req_frame_last,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [edt_pkg::COL_W-1:0]     rsp_centre_col,
   output logic      [edt_pkg::ROW_W-1:0]     rsp_centre_row,
   output logic                               rsp_target_seen,
   output logic      [edt_pkg::COL_W-1:0]     rsp_lost_frames,
   output logic                               rsp_near,
   // register port
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [edt_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [edt_pkg::DATA_W-1:0]    pwdata,
   output logic      [edt_pkg::DATA_W-1:0]    prdata,
   output logic                               pready
);
   import edt_pkg::*;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [ROW_W-1:0]   row_start_ff, row_end_ff;
   logic [COL_W-1:0]   col_start_ff, col_end_ff, lost_limit_ff;
   logic [RANGE_W-1:0] near_limit_ff;
   logic               csr_write;
   reg_index_type      csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_start_ff  <= ROW_START_RST;
         row_end_ff    <= ROW_END_RST;
         col_start_ff  <= COL_START_RST;
         col_end_ff    <= COL_END_RST;
         lost_limit_ff <= LOST_LIMIT_RST;
         near_limit_ff <= NEAR_LIMIT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ROW_START:  row_start_ff  <= pwdata[ROW_W-1:0];
            REG_ROW_END:    row_end_ff    <= pwdata[ROW_W-1:0];
            REG_COL_START:  col_start_ff  <= pwdata[COL_W-1:0];
            REG_COL_END:    col_end_ff    <= pwdata[COL_W-1:0];
            REG_LOST_LIMIT: lost_limit_ff <= pwdata[COL_W-1:0];
            REG_NEAR_LIMIT: near_limit_ff <= pwdata[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   // read back; addresses past the list read as zero
   always_comb begin
      unique case (csr_index)
         REG_ROW_START:  prdata = DATA_W'(row_start_ff);
         REG_ROW_END:    prdata = DATA_W'(row_end_ff);
         REG_COL_START:  prdata = DATA_W'(col_start_ff);
         REG_COL_END:    prdata = DATA_W'(col_end_ff);
         REG_LOST_LIMIT: prdata = DATA_W'(lost_limit_ff);
         REG_NEAR_LIMIT: prdata = DATA_W'(near_limit_ff);
         default:        prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   state_type      state_ff, state_in;
   logic           div_start;
   logic           finish_go;
   logic           use_row;
   div_status_type div_status;
   logic [SUM_W-1:0] div_quotient;
   logic           in_fire;
   logic           out_free;

   logic             prev_pixel_ff;
   logic [ROW_W-1:0] row_pos_ff;
   logic [COL_W-1:0] col_pos_ff;
   logic [CNT_W-1:0] edge_count_ff, edge_count_in;
   logic [SUM_W-1:0] col_sum_ff, col_sum_in;
   logic [SUM_W-1:0] row_sum_ff, row_sum_in;
   logic [COL_W-1:0] held_col_ff, held_col_in;
   logic [ROW_W-1:0] held_row_ff, held_row_in;
   logic [COL_W-1:0] lost_count_ff, lost_count_in;
   logic [COL_W-1:0] col_q_ff;
   logic [ROW_W-1:0] row_q_ff;
   logic             near_ff;
   logic             seen_in;

   logic             rsp_valid_ff;
   logic [COL_W-1:0] rsp_col_ff;
   logic [ROW_W-1:0] rsp_row_ff;
   logic             rsp_seen_ff;
   logic [COL_W-1:0] rsp_lost_ff;
   logic             rsp_near_ff;

   assign in_fire  = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_fire && req_frame_last) begin
               // skip both divisions when the frame saw no transition
               state_in = (edge_count_in == '0) ? ST_FINISH : ST_COL_START;
            end
         end
         ST_COL_START: state_in = ST_COL_WAIT;
         ST_COL_WAIT: begin
            if (div_status.done) begin
               state_in = ST_ROW_START;
            end
         end
         ST_ROW_START: state_in = ST_ROW_WAIT;
         ST_ROW_WAIT: begin
            if (div_status.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      finish_go = 1'b0;
      use_row   = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_ready = 1'b1;
         ST_COL_START: div_start = 1'b1;
         ST_COL_WAIT:  ;
         ST_ROW_START: begin
            div_start = 1'b1;
            use_row   = 1'b1;
         end
         ST_ROW_WAIT:  use_row   = 1'b1;
         ST_FINISH:    finish_go = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ------------------------------------------------------------------------
   // Shared divider: column sum first, then row sum
   // ------------------------------------------------------------------------
   edt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (use_row ? row_sum_ff : col_sum_ff),
      .divisor  (edge_count_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // ------------------------------------------------------------------------
   // Transition scan
   // ------------------------------------------------------------------------
   logic [COL_W-1:0] left_col;
   logic             hit;
   logic [CNT_W:0]   count_sum;
   logic [SUM_W:0]   col_add, row_add;

   always_comb begin
      left_col = col_pos_ff - 1'b1;
      hit = (col_pos_ff != '0) && (req_pixel != prev_pixel_ff)
         && (row_pos_ff >= row_start_ff) && (row_pos_ff <= row_end_ff)
         && (left_col >= col_start_ff) && (left_col <= col_end_ff);
      count_sum = {1'b0, edge_count_ff} + 1'b1;
      col_add   = {1'b0, col_sum_ff} + (SUM_W+1)'(left_col);
      row_add   = {1'b0, row_sum_ff} + (SUM_W+1)'(row_pos_ff);
      edge_count_in = edge_count_ff;
      col_sum_in    = col_sum_ff;
      row_sum_in    = row_sum_ff;
      if (hit) begin
         // saturate instead of wrapping
         edge_count_in = count_sum[CNT_W] ? COUNT_MAX : count_sum[CNT_W-1:0];
         col_sum_in    = col_add[SUM_W]   ? SUM_MAX   : col_add[SUM_W-1:0];
         row_sum_in    = row_add[SUM_W]   ? SUM_MAX   : row_add[SUM_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // Frame-end update of held centre and lost counter
   // ------------------------------------------------------------------------
   logic [COL_W-1:0] lost_step;

   always_comb begin
      held_row_in   = held_row_ff;
      held_col_in   = held_col_ff;
      lost_count_in = lost_count_ff;
      seen_in       = 1'b0;
      lost_step     = lost_count_ff + 1'b1;
      if (row_q_ff != '0) begin
         held_row_in = row_q_ff;
      end
      if (col_q_ff != '0) begin
         held_col_in   = col_q_ff;
         lost_count_in = '0;
         seen_in       = 1'b1;
      end else begin
         lost_count_in = lost_step;
         // drop the column once the target has been missing too long
         if (lost_step > lost_limit_ff) begin
            held_col_in = '0;
         end
         if (lost_step > LOST_WRAP_ABOVE) begin
            lost_count_in = LOST_WRAP_TO;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Frame state
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pixel_ff <= 1'b0;
         row_pos_ff    <= '0;
         col_pos_ff    <= '0;
         edge_count_ff <= '0;
         col_sum_ff    <= '0;
         row_sum_ff    <= '0;
         held_col_ff   <= '0;
         held_row_ff   <= '0;
         lost_count_ff <= '0;
      end else begin
         if (in_fire) begin
            prev_pixel_ff <= req_frame_last ? 1'b0 : req_pixel;
            edge_count_ff <= edge_count_in;
            col_sum_ff    <= col_sum_in;
            row_sum_ff    <= row_sum_in;
            if (req_frame_last) begin
               // restart the raster; sums stay until the divides are done
               col_pos_ff    <= '0;
               row_pos_ff    <= '0;
            end else if (col_pos_ff >= COL_LAST) begin
               col_pos_ff <= '0;
               row_pos_ff <= (row_pos_ff >= ROW_LAST) ? '0 : row_pos_ff + 1'b1;
            end else begin
               col_pos_ff <= col_pos_ff + 1'b1;
            end
         end
         if (finish_go) begin
            held_col_ff   <= held_col_in;
            held_row_ff   <= held_row_in;
            lost_count_ff <= lost_count_in;
            edge_count_ff <= '0;
            col_sum_ff    <= '0;
            row_sum_ff    <= '0;
         end
      end
   end

   // quotients and near flag of the frame in flight
   always_ff @(posedge clock) begin
      if (in_fire && req_frame_last) begin
         col_q_ff <= '0;
         row_q_ff <= '0;
         near_ff  <= (req_range_sample != '0) && (req_range_sample < near_limit_ff);
      end
      if (div_status.done) begin
         if (state_ff == ST_COL_WAIT) begin
            col_q_ff <= div_quotient[COL_W-1:0];
         end else begin
            row_q_ff <= div_quotient[ROW_W-1:0];
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result word register
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish_go) begin
         rsp_col_ff  <= held_col_in;
         rsp_row_ff  <= held_row_in;
         rsp_seen_ff <= seen_in;
         rsp_lost_ff <= lost_count_in;
         rsp_near_ff <= near_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_centre_col  = rsp_col_ff;
   assign rsp_centre_row  = rsp_row_ff;
   assign rsp_target_seen = rsp_seen_ff;
   assign rsp_lost_frames = rsp_lost_ff;
   assign rsp_near        = rsp_near_ff;

endmodule
`default_nettype wire
